/* hdl/cv3_pkg.sv */
// Shared types and constants for the 3x3 convolution block.
package cv3_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned COEF_TOP_W = 48;
  localparam int unsigned COEF_BOT_W = 24;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned TAPS       = 9;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COEF_TOP     = 2'd2,
    REG_COEF_BOTTOM  = 2'd3
  } reg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]    image_width;
    logic [HEIGHT_W-1:0]   image_height;
    logic [COEF_TOP_W-1:0] coef_rows_top;
    logic [COEF_BOT_W-1:0] coef_row_bottom;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    image_width:     11'd512,
    image_height:    16'd512,
    coef_rows_top:   48'd0,
    coef_row_bottom: 24'd0
  };

  // Window handed from the line buffer stage to the multiply stage.
  // Entry i*3+j is row i (0 = oldest row) and column j (0 = oldest column).
  typedef struct packed {
    logic           valid;
    logic           last;
    pix_t [TAPS-1:0] pix;
  } win_t;

endpackage

/* hdl/cv3_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module cv3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cv3_regs.sv */
// APB-style configuration register file.
module cv3_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cv3_pkg::ADDR_W-1:0]   paddr,
  input  logic [cv3_pkg::DATA_W-1:0]   pwdata,
  output logic [cv3_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output cv3_pkg::cfg_t                cfg_o
);
  import cv3_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg_d.image_width     = pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height    = pwdata[HEIGHT_W-1:0];
        REG_COEF_TOP:     cfg_d.coef_rows_top   = pwdata[COEF_TOP_W-1:0];
        REG_COEF_BOTTOM:  cfg_d.coef_row_bottom = pwdata[COEF_BOT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {{(DATA_W-HEIGHT_W){1'b0}}, cfg_q.image_height};
      REG_COEF_TOP:     prdata = {{(DATA_W-COEF_TOP_W){1'b0}}, cfg_q.coef_rows_top};
      REG_COEF_BOTTOM:  prdata = {{(DATA_W-COEF_BOT_W){1'b0}}, cfg_q.coef_row_bottom};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/cv3_window.sv */
// Frame counters, two line buffers and the 3x3 pixel window.
module cv3_window #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cv3_pkg::cfg_t              cfg_i,
  input  logic [cv3_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mac_ready_i,
  output cv3_pkg::win_t              win_o
);
  import cv3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int unsigned RW = HEIGHT_W + 1;

  logic [CW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [WW-1:0]       width_ext, w_eff, col_inc;
  logic [RW-1:0]       row_inc;
  logic                accept, col_wrap, emit, last;

  logic          s1_v_q, s1_v_d;
  logic          s1_emit_q, s1_last_q;
  logic [CW-1:0] s1_col_q;
  pix_t          s1_pix_q;
  logic          fwd_q, fwd_d;
  pix_t          fwd_mid_q, fwd_top_q;
  logic          s1_fire, s1_move;

  pix_t mid_rd, top_rd, mid_s1, top_s1;
  pix_t [TAPS-1:0] win_q, win_d;

  // Frame position of the beat being accepted.
  assign width_ext = WW'(cfg_i.image_width);
  assign w_eff     = (width_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_ext;
  assign col_inc   = WW'(col_q) + WW'(1);
  assign row_inc   = RW'(row_q) + RW'(1);
  assign col_wrap  = (col_inc >= w_eff);
  assign emit      = (row_q >= HEIGHT_W'(2)) && (col_q >= CW'(2));
  assign last      = (row_inc == RW'(cfg_i.image_height)) && (col_inc == w_eff);

  assign s1_fire    = s1_v_q && (!s1_emit_q || mac_ready_i);
  assign s1_move    = !s1_v_q || s1_fire;
  assign accept     = in_valid_i && s1_move;
  assign in_stall_o = !s1_move;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = (row_inc >= RW'(cfg_i.image_height)) ? '0 : row_inc[HEIGHT_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_move) begin
      s1_v_d = in_valid_i;
    end
  end

  // When the previous beat writes the very column this beat reads (rows of
  // one pixel), the RAM still returns the old word, so the data is forwarded.
  assign fwd_d  = s1_fire && (s1_col_q == col_q);
  assign mid_s1 = fwd_q ? fwd_mid_q : mid_rd;
  assign top_s1 = fwd_q ? fwd_top_q : top_rd;

  cv3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  cv3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (mid_s1),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = win_q[i*3+1];
      win_d[i*3 + 1] = win_q[i*3+2];
    end
    win_d[2] = top_s1;
    win_d[5] = mid_s1;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      win_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
      if (s1_fire) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_col_q  <= col_q;
      s1_pix_q  <= pixel_i;
      fwd_q     <= fwd_d;
      fwd_mid_q <= s1_pix_q;
      fwd_top_q <= mid_s1;
    end
  end

  assign win_o.valid = s1_v_q && s1_emit_q;
  assign win_o.last  = s1_last_q;
  assign win_o.pix   = win_d;

endmodule

/* hdl/cv3_mac.sv */
// Nine coefficient multiplies, their product register, the adder tree and the result register.
module cv3_mac #(
  parameter int unsigned COEF_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cv3_pkg::COEF_TOP_W-1:0]    coef_top_i,
  input  logic [cv3_pkg::COEF_BOT_W-1:0]    coef_bot_i,
  input  cv3_pkg::win_t                     win_i,
  output logic                              ready_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cv3_pkg::PIX_W-1:0]         pixel_low_byte_o,
  output logic signed [cv3_pkg::SUM_W-1:0]  window_sum_o,
  output logic                              frame_last_o
);
  import cv3_pkg::*;

  localparam int unsigned PW    = COEF_BITS + PIX_W + 1;
  localparam int unsigned AW    = (PW + 4 > SUM_W) ? PW + 4 : SUM_W;
  localparam int unsigned EXT_W = 128;

  logic [EXT_W-1:0] ext_top, ext_bot;
  logic signed [COEF_BITS-1:0] tap [TAPS];
  logic signed [PW-1:0] prod_d [TAPS];
  logic signed [PW-1:0] prod_q [TAPS];
  logic signed [AW-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;
  logic s2_v_q, s2_last_q, out_v_q, out_last_q;
  logic out_en, s2_take;

  assign ext_top = EXT_W'(coef_top_i);
  assign ext_bot = EXT_W'(coef_bot_i);

  // Taps placed past bit 63 of their register read as zero.
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    localparam int unsigned SH = ((k < 6) ? k : k - 6) * COEF_BITS;
    if (SH >= 64) begin : g_zero
      assign tap[k] = '0;
    end else if (k < 6) begin : g_top
      assign tap[k] = $signed(ext_top[SH +: COEF_BITS]);
    end else begin : g_bot
      assign tap[k] = $signed(ext_bot[SH +: COEF_BITS]);
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_d[k] = PW'($signed({1'b0, win_i.pix[k]})) * PW'(tap[k]);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum_d = sum_d + AW'(prod_q[k]);
    end
  end

  assign out_en  = !out_v_q || !out_stall_i;
  assign s2_take = !s2_v_q || out_en;
  assign ready_o = s2_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_take) begin
        s2_v_q <= win_i.valid;
      end
      if (out_en) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take && win_i.valid) begin
      prod_q    <= prod_d;
      s2_last_q <= win_i.last;
    end
    if (out_en && s2_v_q) begin
      sum_q      <= sum_d[SUM_W-1:0];
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign window_sum_o     = sum_q;
  assign pixel_low_byte_o = sum_q[PIX_W-1:0];
  assign frame_last_o     = out_last_q;

endmodule

/* hdl/conv3x3_integer_kernel_top.sv */
// Top level of the streaming 3x3 integer convolution block.
//
// Grey pixels enter in raster order at one beat per clock while not stalled; each interior
// pixel position yields one result, which passes the line-buffer stage, the multiply stage
// and the result register in turn; border positions yield none. The rate is set by the two
// line buffers, each a MAX_WIDTH x 8 RAM read once and written once per beat, and by a
// pipeline of line-buffer stage, multiply stage and result register that each advance every
// cycle unless the stage ahead is held. The input stalls only when the result register is
// held by the consumer and the stages behind it are full. The line buffers are not cleared
// after reset; their contents are only used once a row has been written. Registers sit at
// byte addresses 8*i on a 64-bit APB-style port: image_width, image_height, coef_rows_top
// (taps 0..5) and coef_row_bottom (taps 6..8).
module conv3x3_integer_kernel_top #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COEF_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cv3_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  output logic [cv3_pkg::PIX_W-1:0]         pixel_low_byte_o,
  output logic signed [cv3_pkg::SUM_W-1:0]  window_sum_o,
  output logic                              frame_last_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cv3_pkg::ADDR_W-1:0]        paddr,
  input  logic [cv3_pkg::DATA_W-1:0]        pwdata,
  output logic [cv3_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import cv3_pkg::*;

  cfg_t cfg;
  win_t win;
  logic mac_ready;

  cv3_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cv3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pixel_i     (pixel_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mac_ready_i (mac_ready),
    .win_o       (win)
  );

  cv3_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .coef_top_i       (cfg.coef_rows_top),
    .coef_bot_i       (cfg.coef_row_bottom),
    .win_i            (win),
    .ready_o          (mac_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_low_byte_o (pixel_low_byte_o),
    .window_sum_o     (window_sum_o),
    .frame_last_o     (frame_last_o)
  );

endmodule

/* hdl/cv3_checker.sv */
// Port-level assertions for the convolution block and their bind to the top level.
module cv3_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic [cv3_pkg::PIX_W-1:0]         pixel_low_byte_o,
  input logic signed [cv3_pkg::SUM_W-1:0]  window_sum_o,
  input logic                              frame_last_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [cv3_pkg::ADDR_W-1:0]        paddr,
  input logic [cv3_pkg::DATA_W-1:0]        pwdata,
  input logic [cv3_pkg::DATA_W-1:0]        prdata,
  input logic                              pready
);
  import cv3_pkg::*;

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(window_sum_o) && $stable(frame_last_o)
       && $stable(pixel_low_byte_o)))
    else $error("result beat changed while stalled");

  // The input is only held back when the result register itself is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // No result can be pending in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

  // A height written is read back on the next cycle.
  a_height_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(psel && penable && pwrite && pready) && psel && !pwrite
     && (paddr == $past(paddr)) && (paddr[ADDR_W-1:3] == REG_IMAGE_HEIGHT))
      |-> (prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0])))
    else $error("image height read-back mismatch");

endmodule

bind conv3x3_integer_kernel_top cv3_checker u_cv3_checker (.*);

/* bench/conv3x3_integer_kernel_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts every convolution result from the observed beats and compares it.
module conv3x3_integer_kernel_checker #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COEF_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cv3_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [cv3_pkg::PIX_W-1:0]         pixel_low_byte_i,
  input  logic signed [cv3_pkg::SUM_W-1:0]  window_sum_i,
  input  logic                              frame_last_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [cv3_pkg::ADDR_W-1:0]        paddr_i,
  input  logic [cv3_pkg::DATA_W-1:0]        pwdata_i,
  input  logic                              pready_i,
  output int                                errors_o,
  output int                                pending_o
);
  import cv3_pkg::*;

  typedef struct {
    pix_t             low_byte;
    logic [SUM_W-1:0] sum;
    logic             last;
  } conv_result_t;

  cfg_t         cfg;
  pix_t         line_prev [MAX_WIDTH];  // row above the current one
  pix_t         line_old  [MAX_WIDTH];  // two rows above
  pix_t         win [3][3];
  int unsigned  col_cnt;
  int unsigned  row_cnt;
  conv_result_t conv_results_q [$];
  int           errors;

  // Signed tap k of the kernel, row-major, tap 0 pairing with the oldest row and column.
  function automatic longint tap_value(int k);
    logic [63:0] regv;
    logic [63:0] raw;
    int unsigned sh;
    regv = (k < 6) ? 64'(cfg.coef_rows_top) : 64'(cfg.coef_row_bottom);
    sh = ((k < 6) ? k : k - 6) * COEF_BITS;
    if (sh >= 64) return 0;
    raw = (regv >> sh) & ((64'd1 << COEF_BITS) - 64'd1);
    if (raw[COEF_BITS-1]) return longint'(raw) - (longint'(1) << COEF_BITS);
    return longint'(raw);
  endfunction

  function automatic void flag_mismatch(string field, longint exp_v, longint act_v);
    errors++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
  endfunction

  task automatic take_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    case (reg_idx_e'(addr[ADDR_W-1:3]))
      REG_IMAGE_WIDTH: begin
        cfg.image_width = data[WIDTH_W-1:0];
      end
      REG_IMAGE_HEIGHT: begin
        cfg.image_height = data[HEIGHT_W-1:0];
      end
      REG_COEF_TOP: begin
        cfg.coef_rows_top = data[COEF_TOP_W-1:0];
      end
      REG_COEF_BOTTOM: begin
        cfg.coef_row_bottom = data[COEF_BOT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_pixel(input pix_t p);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    pix_t         top;
    pix_t         mid;
    longint       acc;
    conv_result_t r;
    w = 32'(cfg.image_width);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(cfg.image_height);
    c = col_cnt;
    top = '0;
    mid = '0;
    if (c < MAX_WIDTH) begin
      top = line_old[c];
      mid = line_prev[c];
      line_old[c] = mid;
      line_prev[c] = p;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    // The window is complete only from the third row and third column on.
    if (row_cnt >= 2 && c >= 2) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc += longint'(win[i][j]) * tap_value(i * 3 + j);
        end
      end
      r.low_byte = acc[PIX_W-1:0];
      r.sum = acc[SUM_W-1:0];
      r.last = (row_cnt + 1 == h) && (c + 1 == w);
      conv_results_q.push_back(r);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic take_result();
    conv_result_t e;
    if (conv_results_q.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected: byte %0d, sum %0d, last %0b",
               $time, pixel_low_byte_i, window_sum_i, frame_last_i);
      return;
    end
    e = conv_results_q.pop_front();
    if (pixel_low_byte_i !== e.low_byte) begin
      flag_mismatch("pixel_low_byte", longint'(e.low_byte), longint'(pixel_low_byte_i));
    end
    if (window_sum_i !== e.sum) begin
      flag_mismatch("window_sum", $signed(e.sum), window_sum_i);
    end
    if (frame_last_i !== e.last) begin
      flag_mismatch("frame_last", longint'(e.last), longint'(frame_last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = CFG_RST;
      foreach (line_prev[i]) begin
        line_prev[i] = '0;
        line_old[i] = '0;
      end
      foreach (win[i, j]) begin
        win[i][j] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      conv_results_q.delete();
      errors = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) take_result();
      if (psel_i && penable_i && pwrite_i && pready_i) take_write(paddr_i, pwdata_i);
      if (in_valid_i && !in_stall_i) take_pixel(pixel_i);
      errors_o <= errors;
      pending_o <= conv_results_q.size();
    end
  end

endmodule

/* bench/conv3x3_integer_kernel_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the 3x3 convolution block: clock, reset, stimulus, idling and verdict.
module conv3x3_integer_kernel_top_tb;
  import cv3_pkg::*;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int          DRAIN_CYC  = 8;
  localparam int          RANDOM_PIX = 100;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  pix_t                    pixel = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [PIX_W-1:0]        pixel_low_byte;
  logic signed [SUM_W-1:0] window_sum;
  logic                    frame_last;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  int                      errors;
  int                      pending;

  // Frame position as the stimulus sees it, used to keep line reads on written entries.
  logic [WIDTH_W-1:0]      cur_w;
  logic [HEIGHT_W-1:0]     cur_h;
  int unsigned             pos_row;
  int unsigned             pos_col;
  bit                      no_gaps;
  int                      stall_run = 0;

  always #5 clk = ~clk;

  conv3x3_integer_kernel_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .pixel_i         (pixel),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pixel_low_byte_o(pixel_low_byte),
    .window_sum_o    (window_sum),
    .frame_last_o    (frame_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  conv3x3_integer_kernel_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .pixel_i         (pixel),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .pixel_low_byte_i(pixel_low_byte),
    .window_sum_i    (window_sum),
    .frame_last_i    (frame_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // Result side: short stalls, a few long ones, and long stretches with no stall.
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 7);
      end else if (r < 70) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else if (r < 78) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(30, 150);
      end
    end
  end

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic pix_t pick_pixel();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return pix_t'($urandom_range(0, 255));
  endfunction

  // Nine taps packed as {top rows register, bottom row register}, top rows in the high bits.
  function automatic logic [71:0] pick_taps();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {9{8'h80}};
    if (r == 1) return {9{8'h7f}};
    if (r == 2) return '0;
    return 72'({$urandom(), $urandom(), $urandom()});
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pos_col + 1 >= eff_width(cur_w)) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= cur_h) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (DRAIN_CYC) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One setting of all four registers followed by npix beats; fill < 0 means random pixels.
  task automatic run_phase(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                           input logic [71:0] taps, input int npix, input int fill,
                           input bit keep_pos);
    int unsigned to_row_end;
    wait_idle();
    if (pos_row != 0 || pos_col != 0) begin
      if (keep_pos) begin
        // A wider row in the middle of a frame would read line entries never written.
        if (eff_width(w) > eff_width(cur_w)) w = cur_w;
      end else begin
        // With a height of one the row count wraps to zero at the end of this row.
        reg_write(REG_IMAGE_HEIGHT, 64'd1);
        cur_h = 16'd1;
        to_row_end = (pos_col + 1 >= eff_width(cur_w)) ? 1 : eff_width(cur_w) - pos_col;
        repeat (to_row_end) send_pixel(pick_pixel());
        wait_idle();
      end
    end
    reg_write(REG_IMAGE_WIDTH, 64'(w));
    reg_write(REG_IMAGE_HEIGHT, 64'(h));
    reg_write(REG_COEF_TOP, 64'(taps[71:24]));
    reg_write(REG_COEF_BOTTOM, 64'(taps[23:0]));
    cur_w = w;
    cur_h = h;
    no_gaps = ($urandom_range(0, 4) == 0);
    repeat (npix) send_pixel((fill < 0) ? pick_pixel() : pix_t'(fill));
  endtask

  initial begin
    logic [71:0] taps;
    int          random_sent;
    int          kind;
    int          w;
    int          h;
    int          npix;
    bit          keep;
    int          drain;
    cur_w = CFG_RST.image_width;
    cur_h = CFG_RST.image_height;
    pos_row = 0;
    pos_col = 0;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frames at the most negative and most positive sums, then an all-zero frame.
    run_phase(3, 3, {9{8'h80}}, 9, 255, 1'b0);
    run_phase(3, 3, {9{8'h7f}}, 9, 255, 1'b0);
    run_phase(3, 3, pick_taps(), 9, 0, 1'b0);

    // An oversized width saturates to the longest line: one such row moves to the next row.
    run_phase(11'h7ff, 3, pick_taps(), MAX_WIDTH, -1, 1'b0);
    // Narrow rows kept in the same frame then reach the third row on the saturated count.
    run_phase(4, 3, pick_taps(), 12, -1, 1'b1);
    run_phase(0, 5, pick_taps(), 8, -1, 1'b0);
    run_phase(7, 0, pick_taps(), 24, -1, 1'b0);
    // A tall frame left open, then new settings while the counters are kept.
    run_phase(5, 16'hffff, pick_taps(), 30, -1, 1'b0);
    run_phase(5, 3, pick_taps(), 12, -1, 1'b1);

    random_sent = 0;
    while (random_sent < RANDOM_PIX) begin
      kind = $urandom_range(0, 9);
      taps = pick_taps();
      keep = 1'b0;
      case (kind)
        0: begin
          w = $urandom_range(0, 2);
          h = $urandom_range(3, 8);
          npix = $urandom_range(6, 20);
        end
        1: begin
          w = $urandom_range(3, 12);
          h = $urandom_range(0, 2);
          npix = $urandom_range(10, 40);
        end
        2: begin
          w = $urandom_range(3, 10);
          h = 16'hffff;
          npix = w * $urandom_range(3, 6);
        end
        3: begin
          if (eff_width(cur_w) > 3 && $urandom_range(0, 1) == 1) begin
            w = $urandom_range(3, eff_width(cur_w));
          end else begin
            w = cur_w;
          end
          h = $urandom_range(3, 8);
          npix = $urandom_range(5, 40);
          keep = 1'b1;
        end
        default: begin
          w = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 12) : $urandom_range(13, 40);
          h = $urandom_range(3, 6);
          npix = w * h * $urandom_range(1, 2);
          if ($urandom_range(0, 3) == 0) npix -= $urandom_range(1, 2 * w);
        end
      endcase
      run_phase(WIDTH_W'(w), HEIGHT_W'(h), taps, npix, -1, keep);
      random_sent += npix;
    end

    in_valid <= 1'b0;
    repeat (DRAIN_CYC) @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* conv3x3_integer_kernel_top.f */
hdl/cv3_pkg.sv
hdl/cv3_ram.sv
hdl/cv3_regs.sv
hdl/cv3_window.sv
hdl/cv3_mac.sv
hdl/conv3x3_integer_kernel_top.sv
hdl/cv3_checker.sv
bench/conv3x3_integer_kernel_checker.sv
bench/conv3x3_integer_kernel_top_tb.sv
